[src/clt_pkg.sv]
package clt_pkg;

	localparam int MAX_DEPTH  = 16;
	localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
	localparam int MAX_RES    = 5;
	localparam int RES_CNT_W  = 3;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LPAR    = 8'h28;
	localparam logic [7:0] CH_RPAR    = 8'h29;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CASE_OFS   = 8'h20;

	typedef enum logic [2:0] {
		EV_CHAR      = 3'd0,
		EV_TOKEN_END = 3'd1,
		EV_CMD_END   = 3'd2,
		EV_ACCEPT    = 3'd3,
		EV_REJECT    = 3'd4
	} ev_t;

	typedef enum logic [1:0] {
		ROLE_VERB  = 2'd0,
		ROLE_ARG   = 2'd1,
		ROLE_NAME  = 2'd2,
		ROLE_VALUE = 2'd3
	} role_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_STRAY = 3'd1,
		ERR_QUOTE = 3'd2,
		ERR_PAREN = 3'd3,
		ERR_DEPTH = 3'd4
	} err_t;

	typedef enum logic [6:0] {
		PH_NONE  = 7'b0000001,
		PH_VERB  = 7'b0000010,
		PH_ARG   = 7'b0000100,
		PH_DASH1 = 7'b0001000,
		PH_DASH2 = 7'b0010000,
		PH_NAME  = 7'b0100000,
		PH_VALUE = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic               quote_open;
		logic [DEPTH_W-1:0] paren_depth;
		logic               comment_skip;
		err_t               pending_error;
		phase_t             token_phase;
		logic               command_started;
	} clt_state_t;

	typedef struct packed {
		ev_t        event_res;
		role_t      role;
		logic [7:0] out_char;
		err_t       error_code;
		logic       last;
	} clt_res_t;

	localparam clt_state_t ST_RESET = '{
		quote_open:      1'b0,
		paren_depth:     '0,
		comment_skip:    1'b0,
		pending_error:   ERR_NONE,
		token_phase:     PH_NONE,
		command_started: 1'b0
	};

endpackage

[src/clt_in_if.sv]
interface clt_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] ch;

	modport source (output valid, output kind, output ch, input ready);
	modport sink (input valid, input kind, input ch, output ready);
endinterface

[src/clt_out_if.sv]
interface clt_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [1:0] role;
	logic [7:0] out_char;
	logic [2:0] error_code;
	logic       last;

	modport source (output valid, output event_res, output role, output out_char,
		output error_code, output last, input ready);
	modport sink (input valid, input event_res, input role, input out_char,
		input error_code, input last, output ready);
endinterface

[src/clt_step.sv]
module clt_step (
	input  clt_pkg::clt_state_t                      st,
	input  logic                                     kind,
	input  logic [7:0]                               ch,
	output clt_pkg::clt_state_t                      nxt,
	output clt_pkg::clt_res_t [clt_pkg::MAX_RES-1:0] res,
	output logic [clt_pkg::RES_CNT_W-1:0]            n
);
	import clt_pkg::*;

	logic               do_tok;
	logic               do_cmd;
	logic               do_push;
	logic               do_acc;
	logic               do_rej;
	err_t               rej_code;
	logic               ok;
	logic               is_space;
	logic [DEPTH_W-1:0] depth_new;
	logic [7:0]         verb_ch;

	function automatic clt_res_t mk_res(ev_t ev, role_t rl, logic [7:0] c, err_t err);
		clt_res_t r;
		r.event_res  = ev;
		r.role       = rl;
		r.out_char   = c;
		r.error_code = err;
		r.last       = 1'b0;
		return r;
	endfunction

	assign is_space = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
	assign verb_ch  = (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) ? ch + CASE_OFS : ch;

	always_comb begin
		nxt       = st;
		n         = '0;
		res       = '0;
		do_tok    = 1'b0;
		do_cmd    = 1'b0;
		do_push   = 1'b0;
		do_acc    = 1'b0;
		do_rej    = 1'b0;
		rej_code  = ERR_NONE;
		ok        = 1'b1;
		depth_new = st.paren_depth;

		if (kind) begin
			if (st.pending_error != ERR_NONE) begin
				do_rej   = 1'b1;
				rej_code = st.pending_error;
			end else if (st.quote_open) begin
				do_rej   = 1'b1;
				rej_code = ERR_QUOTE;
			end else if (st.paren_depth != '0) begin
				do_rej   = 1'b1;
				rej_code = ERR_PAREN;
			end else begin
				do_tok = 1'b1;
				do_cmd = 1'b1;
				do_acc = 1'b1;
			end
		end else if (st.comment_skip || st.pending_error != ERR_NONE) begin
			// rest of line ignored
		end else if (st.quote_open) begin
			if (ch == CH_QUOTE)
				nxt.quote_open = 1'b0;
			else
				do_push = 1'b1;
		end else if (ch == CH_QUOTE) begin
			nxt.quote_open = 1'b1;
		end else if (ch == CH_HASH && st.paren_depth == '0) begin
			nxt.comment_skip = 1'b1;
		end else begin
			if (ch == CH_LPAR) begin
				if (st.paren_depth >= DEPTH_W'(MAX_DEPTH)) begin
					nxt.pending_error = ERR_DEPTH;
					ok = 1'b0;
				end else begin
					depth_new = st.paren_depth + 1'b1;
				end
			end else if (ch == CH_RPAR) begin
				if (st.paren_depth == '0) begin
					nxt.pending_error = ERR_STRAY;
					ok = 1'b0;
				end else begin
					depth_new = st.paren_depth - 1'b1;
				end
			end
			nxt.paren_depth = depth_new;
			if (ok) begin
				if (depth_new == '0 && ch == CH_SEMI) begin
					do_tok = 1'b1;
					do_cmd = 1'b1;
				end else if (is_space) begin
					if (depth_new == '0)
						do_tok = 1'b1;
				end else begin
					do_push = 1'b1;
				end
			end
		end

		if (do_tok) begin
			if (st.token_phase == PH_DASH1 || st.token_phase == PH_DASH2) begin
				res[n] = mk_res(EV_CHAR, ROLE_ARG, CH_DASH, ERR_NONE);
				n = n + 1'b1;
			end
			if (st.token_phase == PH_DASH2) begin
				res[n] = mk_res(EV_CHAR, ROLE_ARG, CH_DASH, ERR_NONE);
				n = n + 1'b1;
			end
			if (st.token_phase != PH_NONE) begin
				res[n] = mk_res(EV_TOKEN_END, ROLE_VERB, 8'h00, ERR_NONE);
				n = n + 1'b1;
			end
			nxt.token_phase = PH_NONE;
		end

		if (do_cmd) begin
			if (st.command_started) begin
				res[n] = mk_res(EV_CMD_END, ROLE_VERB, 8'h00, ERR_NONE);
				n = n + 1'b1;
			end
			nxt.command_started = 1'b0;
		end

		if (do_push) begin
			case (st.token_phase)
				PH_NONE: begin
					if (!st.command_started) begin
						nxt.command_started = 1'b1;
						nxt.token_phase     = PH_VERB;
						res[n] = mk_res(EV_CHAR, ROLE_VERB, verb_ch, ERR_NONE);
						n = n + 1'b1;
					end else if (ch == CH_DASH) begin
						nxt.token_phase = PH_DASH1;
					end else begin
						nxt.token_phase = PH_ARG;
						res[n] = mk_res(EV_CHAR, ROLE_ARG, ch, ERR_NONE);
						n = n + 1'b1;
					end
				end
				PH_VERB: begin
					res[n] = mk_res(EV_CHAR, ROLE_VERB, verb_ch, ERR_NONE);
					n = n + 1'b1;
				end
				PH_DASH1: begin
					if (ch == CH_DASH) begin
						nxt.token_phase = PH_DASH2;
					end else begin
						res[n] = mk_res(EV_CHAR, ROLE_ARG, CH_DASH, ERR_NONE);
						n = n + 1'b1;
						res[n] = mk_res(EV_CHAR, ROLE_ARG, ch, ERR_NONE);
						n = n + 1'b1;
						nxt.token_phase = PH_ARG;
					end
				end
				PH_DASH2, PH_NAME: begin
					if (ch == CH_EQ) begin
						nxt.token_phase = PH_VALUE;
					end else begin
						res[n] = mk_res(EV_CHAR, ROLE_NAME, ch, ERR_NONE);
						n = n + 1'b1;
						nxt.token_phase = PH_NAME;
					end
				end
				PH_VALUE: begin
					res[n] = mk_res(EV_CHAR, ROLE_VALUE, ch, ERR_NONE);
					n = n + 1'b1;
				end
				default: begin
					res[n] = mk_res(EV_CHAR, ROLE_ARG, ch, ERR_NONE);
					n = n + 1'b1;
					nxt.token_phase = PH_ARG;
				end
			endcase
		end

		if (do_acc) begin
			res[n] = mk_res(EV_ACCEPT, ROLE_VERB, 8'h00, ERR_NONE);
			n = n + 1'b1;
		end
		if (do_rej) begin
			res[n] = mk_res(EV_REJECT, ROLE_VERB, 8'h00, rej_code);
			n = n + 1'b1;
		end

		if (n != '0)
			res[n - 1'b1].last = 1'b1;

		if (kind)
			nxt = ST_RESET;
	end

endmodule

[src/command_line_tokenizer_core.sv]
// Pipeline: an accepted transaction is registered in the input stage, decoded once the result
// queue has room, and its results are written to the queue, whose head is offered on the output.
// Throughput: one input transaction per cycle while the 8-entry result queue has room for 5;
// the output drains one result per cycle while ready is high, so the sustained rate follows the result count.
// Reset: arst_n clears the tokenizer state, the input stage valid and the result queue.
module command_line_tokenizer_core (
	input  logic     clk,
	input  logic     arst_n,
	clt_in_if.sink   item,
	clt_out_if.source result
);
	import clt_pkg::*;

	logic                        valid_s1;
	logic                        kind_s1;
	logic [7:0]                  ch_s1;
	clt_state_t                  st_q;
	clt_state_t                  st_nxt;
	clt_res_t [MAX_RES-1:0]      res;
	logic [RES_CNT_W-1:0]        n;
	clt_res_t                    fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]          wr_ptr_q;
	logic [FIFO_AW-1:0]          rd_ptr_q;
	logic [FIFO_CW-1:0]          count_q;
	logic                        space;
	logic                        process;
	logic                        pop;
	logic                        load;
	clt_res_t                    head;

	clt_step u_step (
		.st   (st_q),
		.kind (kind_s1),
		.ch   (ch_s1),
		.nxt  (st_nxt),
		.res  (res),
		.n    (n)
	);

	assign space      = count_q <= FIFO_CW'(FIFO_DEPTH - MAX_RES);
	assign process    = valid_s1 && space;
	assign item.ready = !valid_s1 || process;
	assign load       = item.valid && item.ready;

	assign head              = fifo_q[rd_ptr_q];
	assign result.valid      = count_q != '0;
	assign result.event_res  = head.event_res;
	assign result.role       = head.role;
	assign result.out_char   = head.out_char;
	assign result.error_code = head.error_code;
	assign result.last       = head.last;
	assign pop               = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= ST_RESET;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (load)
				valid_s1 <= 1'b1;
			else if (process)
				valid_s1 <= 1'b0;
			if (process) begin
				st_q     <= st_nxt;
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(n);
			end
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (process ? FIFO_CW'(n) : '0) - (pop ? FIFO_CW'(1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_s1 <= item.kind;
			ch_s1   <= item.ch;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (process && RES_CNT_W'(i) < n)
				fifo_q[wr_ptr_q + FIFO_AW'(i)] <= res[i];
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.paren_depth <= DEPTH_W'(MAX_DEPTH))
		else $error("paren depth beyond limit");

	a_eol_result: assert property (@(posedge clk) disable iff (!arst_n)
		(process && kind_s1) |-> n != '0)
		else $error("end of line gave no status");

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(process && kind_s1) |=> st_q == ST_RESET)
		else $error("state not cleared after end of line");
`endif

endmodule

[dv/tb_command_line_tokenizer_core.sv]
`timescale 1ns / 100ps

module tb_command_line_tokenizer_core;
	import clt_pkg::*;

	localparam bit KIND_CHAR = 1'b0;
	localparam bit KIND_EOL  = 1'b1;
	localparam int RANDOM_ITEMS = 360;
	localparam int CALM_TAIL    = 60;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	class clt_token_scoreboard;
		clt_res_t   expected_q[$];
		clt_res_t   step_res[$];
		int         mismatches;
		bit         quote_open;
		int unsigned depth;
		bit         comment_skip;
		err_t       pending_err;
		phase_t     tok_phase;
		bit         cmd_started;

		function new();
			mismatches = 0;
			clear_state();
		endfunction

		function void clear_state();
			quote_open   = 1'b0;
			depth        = 0;
			comment_skip = 1'b0;
			pending_err  = ERR_NONE;
			tok_phase    = PH_NONE;
			cmd_started  = 1'b0;
		endfunction

		function void emit(ev_t ev, role_t r, logic [7:0] c, err_t e);
			clt_res_t x;
			x.event_res  = ev;
			x.role       = r;
			x.out_char   = c;
			x.error_code = e;
			x.last       = 1'b0;
			step_res = {step_res, x};
		endfunction

		function void emit_char(role_t r, logic [7:0] c);
			emit(EV_CHAR, r, c, ERR_NONE);
		endfunction

		function logic [7:0] to_lower(logic [7:0] c);
			if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
				return c + CASE_OFS;
			end
			return c;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function void push_char(logic [7:0] c);
			case (tok_phase)
				PH_NONE: begin
					if (!cmd_started) begin
						cmd_started = 1'b1;
						tok_phase = PH_VERB;
						emit_char(ROLE_VERB, to_lower(c));
					end else if (c == CH_DASH) begin
						tok_phase = PH_DASH1;
					end else begin
						tok_phase = PH_ARG;
						emit_char(ROLE_ARG, c);
					end
				end
				PH_VERB: emit_char(ROLE_VERB, to_lower(c));
				PH_DASH1: begin
					if (c == CH_DASH) begin
						tok_phase = PH_DASH2;
					end else begin
						emit_char(ROLE_ARG, CH_DASH);
						emit_char(ROLE_ARG, c);
						tok_phase = PH_ARG;
					end
				end
				PH_DASH2, PH_NAME: begin
					if (c == CH_EQ) begin
						tok_phase = PH_VALUE;
					end else begin
						emit_char(ROLE_NAME, c);
						tok_phase = PH_NAME;
					end
				end
				PH_VALUE: emit_char(ROLE_VALUE, c);
				default: begin
					emit_char(ROLE_ARG, c);
					tok_phase = PH_ARG;
				end
			endcase
		endfunction

		function void close_token();
			if (tok_phase == PH_DASH1) begin
				emit_char(ROLE_ARG, CH_DASH);
			end else if (tok_phase == PH_DASH2) begin
				emit_char(ROLE_ARG, CH_DASH);
				emit_char(ROLE_ARG, CH_DASH);
			end
			if (tok_phase != PH_NONE) begin
				emit(EV_TOKEN_END, ROLE_VERB, 8'h00, ERR_NONE);
			end
			tok_phase = PH_NONE;
		endfunction

		function void close_command();
			close_token();
			if (cmd_started) begin
				emit(EV_CMD_END, ROLE_VERB, 8'h00, ERR_NONE);
			end
			cmd_started = 1'b0;
		endfunction

		// returns 0 when the transaction falls in a comment or after an error
		function bit note_input(bit kind, logic [7:0] c);
			bit live;
			bit ok;
			live = 1'b1;
			step_res.delete();
			if (kind == KIND_EOL) begin
				if (pending_err != ERR_NONE) begin
					emit(EV_REJECT, ROLE_VERB, 8'h00, pending_err);
				end else if (quote_open) begin
					emit(EV_REJECT, ROLE_VERB, 8'h00, ERR_QUOTE);
				end else if (depth != 0) begin
					emit(EV_REJECT, ROLE_VERB, 8'h00, ERR_PAREN);
				end else begin
					close_command();
					emit(EV_ACCEPT, ROLE_VERB, 8'h00, ERR_NONE);
				end
				clear_state();
			end else if (comment_skip || pending_err != ERR_NONE) begin
				live = 1'b0;
			end else if (quote_open) begin
				if (c == CH_QUOTE) begin
					quote_open = 1'b0;
				end else begin
					push_char(c);
				end
			end else if (c == CH_QUOTE) begin
				quote_open = 1'b1;
			end else if (c == CH_HASH && depth == 0) begin
				comment_skip = 1'b1;
			end else begin
				ok = 1'b1;
				if (c == CH_LPAR) begin
					if (depth >= MAX_DEPTH) begin
						pending_err = ERR_DEPTH;
						ok = 1'b0;
					end else begin
						depth++;
					end
				end else if (c == CH_RPAR) begin
					if (depth == 0) begin
						pending_err = ERR_STRAY;
						ok = 1'b0;
					end else begin
						depth--;
					end
				end
				if (ok) begin
					if (depth == 0 && c == CH_SEMI) begin
						close_command();
					end else if (depth == 0 && is_blank(c)) begin
						close_token();
					end else if (!(depth > 0 && is_blank(c))) begin
						push_char(c);
					end
				end
			end
			if (step_res.size() > 0) begin
				step_res[step_res.size() - 1].last = 1'b1;
			end
			expected_q = {expected_q, step_res};
			return live;
		endfunction

		function void report(string what, clt_res_t want, clt_res_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s: exp ev=%0d role=%0d ch=%02h err=%0d last=%0b", what,
					want.event_res, want.role, want.out_char, want.error_code, want.last);
				$display("    got ev=%0d role=%0d ch=%02h err=%0d last=%0b",
					got.event_res, got.role, got.out_char, got.error_code, got.last);
			end
		endfunction

		function void check_result(clt_res_t got);
			clt_res_t want;
			if (expected_q.size() == 0) begin
				want = '0;
				report("unexpected result", want, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.event_res !== want.event_res || got.role !== want.role ||
					got.out_char !== want.out_char || got.error_code !== want.error_code ||
					got.last !== want.last) begin
				report("result mismatch", want, got);
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	clt_in_if  item_if();
	clt_out_if result_if();

	command_line_tokenizer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	clt_token_scoreboard sb;
	logic [7:0] line_bytes[$];
	int  live_items;
	int  idle_cycles;
	bit  idle_on;
	bit  stall_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int hold;
		hold = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && stall_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 10);
			end
			if (hold > 0) begin
				result_if.ready <= 1'b0;
				hold--;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		clt_res_t got;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				got.event_res  = ev_t'(result_if.event_res);
				got.role       = role_t'(result_if.role);
				got.out_char   = result_if.out_char;
				got.error_code = err_t'(result_if.error_code);
				got.last       = result_if.last;
				sb.check_result(got);
			end
			if ((result_if.valid && result_if.ready) || (item_if.valid && item_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(bit k, logic [7:0] c);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			item_if.valid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(negedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.kind  <= k;
		item_if.ch    <= c;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		if (sb.note_input(k, c)) live_items++;
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_bytes[i]) send_item(KIND_CHAR, line_bytes[i]);
		send_item(KIND_EOL, 8'($urandom_range(0, 255)));
		line_bytes.delete();
	endtask

	function void put_byte(logic [7:0] b);
		line_bytes = {line_bytes, b};
	endfunction

	function void add_str(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endfunction

	function void add_word();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			case ($urandom_range(0, 7))
				0, 1: put_byte(CH_UPPER_A + 8'($urandom_range(0, 25)));
				2, 3: put_byte(8'h61 + 8'($urandom_range(0, 25)));
				4: put_byte(8'h30 + 8'($urandom_range(0, 9)));
				5: put_byte(8'h40);
				6: put_byte(8'h5B);
				default: put_byte(8'h5F);
			endcase
		end
	endfunction

	function void add_sep();
		case ($urandom_range(0, 7))
			0, 1: put_byte(CH_SPACE);
			2: put_byte(CH_TAB);
			3: put_byte(8'($urandom_range(10, 13)));
			4: put_byte(CH_SEMI);
			5: add_str("; ");
			6: add_str("  ");
			default: ;
		endcase
	endfunction

	function void add_token();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2: add_word();
			3, 4: begin
				add_str("--");
				if ($urandom_range(0, 3) != 0) add_word();
				if ($urandom_range(0, 1) == 1) begin
					put_byte(CH_EQ);
					if ($urandom_range(0, 3) != 0) add_word();
					if ($urandom_range(0, 3) == 0) add_str("=-");
				end
			end
			5: begin
				put_byte(CH_DASH);
				case ($urandom_range(0, 2))
					0: add_word();
					1: put_byte(CH_DASH);
					default: ;
				endcase
			end
			6: begin
				put_byte(CH_QUOTE);
				n = $urandom_range(0, 4);
				repeat (n) begin
					case ($urandom_range(0, 4))
						0: add_word();
						1: add_str(" ;");
						2: add_str("#(");
						3: add_str(")\t");
						default: put_byte(8'($urandom_range(128, 255)));
					endcase
				end
				put_byte(CH_QUOTE);
			end
			7: begin
				put_byte(CH_LPAR);
				add_word();
				add_str(" ;\t");
				if ($urandom_range(0, 1) == 1) begin
					put_byte(CH_LPAR);
					add_word();
					add_str("# ");
					put_byte(CH_RPAR);
				end
				put_byte(CH_RPAR);
			end
			8: put_byte(8'($urandom_range(0, 255)));
			default: begin
				add_word();
				add_str("\"a b\"");
				add_word();
			end
		endcase
	endfunction

	function void build_line();
		int n;
		case ($urandom_range(0, 19))
			0: begin
				n = $urandom_range(14, 18);
				repeat (n) put_byte(CH_LPAR);
				if ($urandom_range(0, 1) == 1) add_word();
				n = $urandom_range(0, 18);
				repeat (n) put_byte(CH_RPAR);
			end
			1: begin
				n = $urandom_range(1, 8);
				repeat (n) put_byte(8'($urandom_range(0, 255)));
			end
			default: begin
				if ($urandom_range(0, 3) == 0) add_sep();
				n = $urandom_range(0, 5);
				repeat (n) begin
					add_token();
					add_sep();
				end
				case ($urandom_range(0, 9))
					0: put_byte(CH_RPAR);
					1: put_byte(CH_LPAR);
					2: put_byte(CH_QUOTE);
					3: begin
						put_byte(CH_HASH);
						n = $urandom_range(0, 3);
						repeat (n) put_byte(8'($urandom_range(0, 255)));
					end
					default: ;
				endcase
			end
		endcase
	endfunction

	initial begin
		sb = new();
		live_items = 0;
		idle_cycles = 0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.kind  = KIND_CHAR;
		item_if.ch    = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// flag, held dashes, NUL as text, comment
		add_str("Z --a=b -- -");
		put_byte(8'h00);
		add_str(" #c");
		send_line();
		// empty quotes, empty command, stray close
		add_str("\"\";)");
		send_line();
		// blank dropped inside parens, open paren at end of line
		add_str("(\t");
		send_line();
		// open quote, top byte as verb
		put_byte(CH_QUOTE);
		put_byte(8'hFF);
		send_line();

		live_items = 0;
		while (live_items < RANDOM_ITEMS) begin
			idle_on  = live_items < RANDOM_ITEMS - CALM_TAIL;
			stall_on = idle_on;
			build_line();
			send_line();
		end
		item_if.valid <= 1'b0;

		while (sb.outstanding() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[command_line_tokenizer_core.f]
src/clt_pkg.sv
src/clt_in_if.sv
src/clt_out_if.sv
src/clt_step.sv
src/command_line_tokenizer_core.sv
dv/tb_command_line_tokenizer_core.sv
